FILE: sv/pcbs_pkg.sv
package pcbs_pkg;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [6:0]         box_class;
        logic               box_last;
    } t_box_in;

    typedef struct packed {
        logic [5:0] box_index;
        logic       keep;
        logic       result_last;
    } t_box_out;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [6:0]         box_class;
    } t_box_entry;

    localparam logic [0:0] CFG_IOU_THRESHOLD = 1'd0;
    localparam logic [0:0] CFG_MAX_KEPT      = 1'd1;
    localparam int         CFG_ADDR_W        = 1;
    localparam int         CFG_DATA_W        = 9;
    localparam logic [8:0] IOU_THR_RESET     = 9'd128;
    localparam logic [6:0] MAX_KEPT_RESET    = 7'd64;

endpackage

FILE: sv/pcbs_iou.sv
// Pairwise overlap test, 4 register stages. o_hit = pair overlaps too much.
module pcbs_iou (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  pcbs_pkg::t_box_entry i_a,
    input  pcbs_pkg::t_box_entry i_b,
    input  logic [8:0]           i_thr,
    output logic                 o_valid,
    output logic                 o_hit
);
    // stage 1: extents
    logic               r_v1;
    logic signed [18:0] r_iw, r_ih;
    logic [16:0]        r_wa, r_ha, r_wb, r_hb;
    logic               r_v2;
    logic [35:0]        r_inter, r_area_a, r_area_b;
    logic               r_v3;
    logic [35:0]        r_inter3;
    logic [37:0]        r_union;
    logic               r_v4;
    logic [43:0]        r_lhs;
    logic [46:0]        r_rhs;

    logic signed [17:0] ra, rb, ba, bb, min_r, max_l, min_b, max_t;
    logic signed [18:0] n_iw, n_ih;

    always_comb begin
        ra = 18'(i_a.box_left) + 18'($signed({2'b0, i_a.box_width}));
        rb = 18'(i_b.box_left) + 18'($signed({2'b0, i_b.box_width}));
        ba = 18'(i_a.box_top) + 18'($signed({2'b0, i_a.box_height}));
        bb = 18'(i_b.box_top) + 18'($signed({2'b0, i_b.box_height}));
        min_r = (ra < rb) ? ra : rb;
        max_l = (i_a.box_left > i_b.box_left) ? 18'(i_a.box_left) : 18'(i_b.box_left);
        min_b = (ba < bb) ? ba : bb;
        max_t = (i_a.box_top > i_b.box_top) ? 18'(i_a.box_top) : 18'(i_b.box_top);
        n_iw = 19'(min_r) - 19'(max_l) + 19'sd16;
        n_ih = 19'(min_b) - 19'(max_t) + 19'sd16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_iw <= n_iw[18] ? 19'sd0 : n_iw;
        r_ih <= n_ih[18] ? 19'sd0 : n_ih;
        r_wa <= 17'(i_a.box_width) + 17'd16;
        r_ha <= 17'(i_a.box_height) + 17'd16;
        r_wb <= 17'(i_b.box_width) + 17'd16;
        r_hb <= 17'(i_b.box_height) + 17'd16;
        // stage 2: three products (iw, ih at most 17 bits after clamp)
        r_inter  <= 36'(r_iw[17:0]) * 36'(r_ih[17:0]);
        r_area_a <= 36'(r_wa) * 36'(r_ha);
        r_area_b <= 36'(r_wb) * 36'(r_hb);
        // stage 3: union (always positive)
        r_inter3 <= r_inter;
        r_union  <= 38'(r_area_a) + 38'(r_area_b) - 38'(r_inter);
        // stage 4: scale both sides
        r_lhs <= {r_inter3, 8'd0};
        r_rhs <= 47'(r_union) * 47'(i_thr);
    end

    assign o_valid = r_v4;
    assign o_hit   = (47'(r_lhs) > r_rhs);
endmodule

FILE: sv/pcbs_front.sv
// Load side: stores boxes, raises a start strobe on the last one.
module pcbs_front #(
    parameter int MAX_BOXES = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pcbs_pkg::t_box_in    i_data,
    input  logic                 i_busy,
    output logic                 o_full,
    output logic                 o_start,
    output logic [CNT_W-1:0]     o_count,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output pcbs_pkg::t_box_entry o_rd_data
);
    pcbs_pkg::t_box_entry r_mem [MAX_BOXES];
    logic [CNT_W-1:0] r_count, n_count;
    logic r_start;
    logic acc;

    assign o_full = i_busy | r_start;
    assign acc = i_push & ~o_full;

    always_comb begin
        n_count = r_count;
        if (acc) begin
            if (i_data.box_last) n_count = '0;
            else if (r_count < CNT_W'(MAX_BOXES)) n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= 1'b0;
            o_count <= '0;
        end else begin
            r_count <= n_count;
            r_start <= acc & i_data.box_last;
            if (acc & i_data.box_last)
                o_count <= (r_count < CNT_W'(MAX_BOXES)) ? r_count + 1'b1 : r_count;
        end
        if (acc && r_count < CNT_W'(MAX_BOXES))
            r_mem[r_count[IDX_W-1:0]] <= '{i_data.box_left, i_data.box_top,
                i_data.box_width, i_data.box_height, i_data.box_class};
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_start = r_start;
endmodule

FILE: sv/pcbs_back.sv
// Suppression sequencer and result queue.
module pcbs_back #(
    parameter int MAX_BOXES = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CNT_W-1:0]     i_count,
    output logic [IDX_W-1:0]     o_rd_addr,
    input  pcbs_pkg::t_box_entry i_rd_data,
    input  logic [8:0]           i_thr,
    input  logic [6:0]           i_max_kept,
    output logic                 o_busy,
    output logic                 o_empty,
    input  logic                 i_pop,
    output pcbs_pkg::t_box_out   o_data
);
    // compare width for the kept count against the 7-bit cap
    localparam int KW = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDI   = 7'b0000010,
        S_LATI  = 7'b0000100,
        S_RDJ   = 7'b0001000,
        S_LATJ  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [MAX_BOXES-1:0] r_sup;
    logic [CNT_W-1:0] r_n, r_i, r_j, r_kept;
    pcbs_pkg::t_box_entry r_a, r_b;
    logic r_go;
    logic iou_v, iou_hit;
    logic r_full;
    logic emit_now;
    pcbs_pkg::t_box_out r_out;

    pcbs_iou u_iou (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_go), .i_a(r_a), .i_b(r_b),
        .i_thr(i_thr), .o_valid(iou_v), .o_hit(iou_hit)
    );

    assign o_busy  = (r_state != S_IDLE);
    assign o_empty = ~r_full;
    assign o_data  = r_out;
    assign o_rd_addr = (r_state == S_RDI) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];
    // a result word is queued when the output slot is free or being popped
    assign emit_now = (r_state == S_EMIT) && (!r_full || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sup   <= '0;
            r_full  <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= (r_state == S_LATJ) && (i_rd_data.box_class == r_a.box_class);
            r_full <= emit_now | (r_full & ~i_pop);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n <= i_count;
                        r_i <= '0;
                        r_sup <= '0;
                        r_kept <= '0;
                        r_state <= (i_count == '0) ? S_IDLE : S_RDI;
                    end
                end
                S_RDI: begin
                    if (r_i + 1'b1 >= r_n) begin
                        r_i <= '0;
                        r_state <= S_EMIT;
                    end else if (r_sup[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_i + 1'b1;
                        r_state <= S_LATI;
                    end
                end
                S_LATI: begin
                    r_a <= i_rd_data;
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    if (r_j >= r_n) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RDI;
                    end else if (r_sup[r_j[IDX_W-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_LATJ;
                    end
                end
                S_LATJ: begin
                    r_b <= i_rd_data;
                    if (i_rd_data.box_class == r_a.box_class) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end
                end
                S_WAIT: begin
                    if (iou_v) begin
                        if (iou_hit) r_sup[r_j[IDX_W-1:0]] <= 1'b1;
                        r_j <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end
                end
                S_EMIT: begin
                    if (emit_now) begin
                        r_out.box_index <= 6'(r_i);
                        r_out.result_last <= (r_i + 1'b1 == r_n);
                        if (!r_sup[r_i[IDX_W-1:0]] && r_kept < r_n
                            && KW'(r_kept) < KW'(i_max_kept)) begin
                            r_out.keep <= 1'b1;
                            r_kept <= r_kept + 1'b1;
                        end else begin
                            r_out.keep <= 1'b0;
                        end
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_n) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/per_class_box_suppression_core.sv
// channel | direction | handshake     | word
// box in  | in        | push / full   | pcbs_pkg::t_box_in
// result  | out       | pop / empty   | pcbs_pkg::t_box_out
// config  | in        | cfg_we        | index + 9-bit data
// Loading accepts one box per cycle while full is low; the last box starts the
// sweep. Suppressed i boxes are skipped; each live one is latched, then each
// later box j is skipped if suppressed or of another class, or run through
// the pipelined overlap unit (4 stages); then one result per cycle while popped.
// Reset is synchronous active low; the box memory is not cleared.
// full stays high from the last box until the final result is queued.
module per_class_box_suppression_core #(
    parameter int MAX_BOXES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  pcbs_pkg::t_box_in     i_box,
    output logic                  empty,
    input  logic                  pop,
    output pcbs_pkg::t_box_out    o_result,
    input  logic                  i_cfg_we,
    input  logic [pcbs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pcbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [8:0] r_thr;
    logic [6:0] r_max_kept;
    logic busy, start;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] rd_addr;
    pcbs_pkg::t_box_entry rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= pcbs_pkg::IOU_THR_RESET;
            r_max_kept <= pcbs_pkg::MAX_KEPT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pcbs_pkg::CFG_IOU_THRESHOLD: r_thr <= i_cfg_data;
                pcbs_pkg::CFG_MAX_KEPT:      r_max_kept <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    pcbs_front #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(i_box),
        .i_busy(busy), .o_full(full), .o_start(start), .o_count(count),
        .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    pcbs_back #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_count(count),
        .o_rd_addr(rd_addr), .i_rd_data(rd_data), .i_thr(r_thr),
        .i_max_kept(r_max_kept), .o_busy(busy), .o_empty(empty), .i_pop(pop),
        .o_data(o_result)
    );
endmodule
